>>> rtl/humidity_frame_heat_index_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sensor frame heat index block
// Immediate-style wrappers around concurrent properties; empty in synthesis.
// ---------------------------------------------------------------------------
`ifndef HUMIDITY_FRAME_HEAT_INDEX_ASSERT_SVH
`define HUMIDITY_FRAME_HEAT_INDEX_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define HFHI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked while out of reset.
`define HFHI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define HFHI_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define HFHI_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

>>> rtl/hfhi_pkg.sv
// ---------------------------------------------------------------------------
// hfhi_pkg
// Shared types, constants and the heat-stress table of the frame decoder.
// ---------------------------------------------------------------------------
package hfhi_pkg;

    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam int          TEMP_ROWS = 22;
    localparam int          HUM_COLS  = 17;
    localparam int          QUEUE_DEPTH = 2;

    // Byte positions inside the eight-byte frame
    localparam logic [2:0] POS_FIRST    = 3'd0;
    localparam logic [2:0] POS_HUM_HI   = 3'd2;
    localparam logic [2:0] POS_HUM_LO   = 3'd3;
    localparam logic [2:0] POS_TEMP_HI  = 3'd4;
    localparam logic [2:0] POS_TEMP_LO  = 3'd5;
    localparam logic [2:0] POS_CRC_LO   = 3'd6;
    localparam logic [2:0] POS_CRC_HI   = 3'd7;

    // Risk codes
    localparam logic [2:0] RISK_SAFE    = 3'd0;
    localparam logic [2:0] RISK_CAUTION = 3'd1;
    localparam logic [2:0] RISK_WARNING = 3'd2;
    localparam logic [2:0] RISK_STRICT  = 3'd3;
    localparam logic [2:0] RISK_DANGER  = 3'd4;

    // Decoded frame handed from the front end to the back end
    typedef struct packed {
        logic               crc_ok;
        logic signed [15:0] humidity_tenths;
        logic signed [15:0] temperature_tenths;
    } frame_rec_t;

    // Queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    localparam logic [5:0] HEAT_TABLE [TEMP_ROWS][HUM_COLS] = '{
        '{6'd15, 6'd15, 6'd16, 6'd16, 6'd17, 6'd17, 6'd18, 6'd19, 6'd19,
          6'd20, 6'd20, 6'd21, 6'd21, 6'd22, 6'd23, 6'd23, 6'd24},
        '{6'd15, 6'd16, 6'd17, 6'd17, 6'd18, 6'd18, 6'd19, 6'd19, 6'd20,
          6'd21, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24, 6'd24, 6'd25},
        '{6'd16, 6'd17, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20, 6'd20, 6'd21,
          6'd22, 6'd22, 6'd23, 6'd23, 6'd24, 6'd25, 6'd25, 6'd26},
        '{6'd17, 6'd18, 6'd18, 6'd19, 6'd19, 6'd20, 6'd21, 6'd21, 6'd22,
          6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26, 6'd26, 6'd27},
        '{6'd18, 6'd18, 6'd19, 6'd20, 6'd20, 6'd21, 6'd22, 6'd22, 6'd23,
          6'd23, 6'd24, 6'd25, 6'd25, 6'd26, 6'd27, 6'd27, 6'd28},
        '{6'd18, 6'd19, 6'd20, 6'd20, 6'd21, 6'd22, 6'd22, 6'd23, 6'd24,
          6'd24, 6'd25, 6'd26, 6'd26, 6'd27, 6'd28, 6'd28, 6'd29},
        '{6'd19, 6'd20, 6'd21, 6'd21, 6'd22, 6'd23, 6'd23, 6'd24, 6'd25,
          6'd25, 6'd26, 6'd27, 6'd27, 6'd28, 6'd29, 6'd29, 6'd30},
        '{6'd20, 6'd21, 6'd21, 6'd22, 6'd23, 6'd23, 6'd24, 6'd25, 6'd25,
          6'd26, 6'd27, 6'd28, 6'd28, 6'd29, 6'd30, 6'd30, 6'd31},
        '{6'd21, 6'd21, 6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26, 6'd26,
          6'd27, 6'd28, 6'd29, 6'd29, 6'd30, 6'd31, 6'd31, 6'd32},
        '{6'd21, 6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26, 6'd27, 6'd27,
          6'd28, 6'd29, 6'd29, 6'd30, 6'd31, 6'd32, 6'd32, 6'd33},
        '{6'd22, 6'd23, 6'd24, 6'd24, 6'd25, 6'd26, 6'd27, 6'd27, 6'd28,
          6'd29, 6'd30, 6'd30, 6'd31, 6'd32, 6'd33, 6'd33, 6'd34},
        '{6'd23, 6'd24, 6'd25, 6'd25, 6'd26, 6'd27, 6'd28, 6'd28, 6'd29,
          6'd30, 6'd31, 6'd31, 6'd32, 6'd33, 6'd34, 6'd34, 6'd35},
        '{6'd24, 6'd25, 6'd25, 6'd26, 6'd27, 6'd28, 6'd28, 6'd29, 6'd30,
          6'd31, 6'd32, 6'd32, 6'd33, 6'd34, 6'd35, 6'd35, 6'd36},
        '{6'd25, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd29, 6'd30, 6'd31,
          6'd32, 6'd33, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd37},
        '{6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd29, 6'd30, 6'd31, 6'd32,
          6'd33, 6'd33, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd38},
        '{6'd26, 6'd27, 6'd28, 6'd29, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
          6'd34, 6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd39},
        '{6'd27, 6'd28, 6'd29, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd35,
          6'd35, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41},
        '{6'd28, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35,
          6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42},
        '{6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd35,
          6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43},
        '{6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd35, 6'd36,
          6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44},
        '{6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd35, 6'd36, 6'd37,
          6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45},
        '{6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd35, 6'd36, 6'd37, 6'd38,
          6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd46}
    };

    // One Modbus CRC-16 byte step, reflected, eight bit steps
    function automatic logic [15:0] crc_fold(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

>>> rtl/hfhi_queue.sv
// ---------------------------------------------------------------------------
// hfhi_queue
// Two-entry queue of decoded frames between the front and back ends.
// ---------------------------------------------------------------------------
module hfhi_queue
    import hfhi_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  frame_rec_t    push_rec,
    input  logic          pop,
    output frame_rec_t    pop_rec,
    output queue_status_t status
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);

    frame_rec_t      mem_reg [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PtrW:0]   count_reg;

    assign status.full  = (count_reg == (PtrW+1)'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_rec      = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

>>> rtl/hfhi_front.sv
// ---------------------------------------------------------------------------
// hfhi_front
// Byte intake: frame position, running CRC and capture of the data bytes.
// ---------------------------------------------------------------------------
module hfhi_front
    import hfhi_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // [7:0] frame_byte
    input  logic          s_tuser,   // [0] frame_start
    input  queue_status_t q_status,
    output logic          push,
    output frame_rec_t    push_rec
);

    logic [2:0]  pos_reg, pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  hum_hi_reg, hum_lo_reg, temp_hi_reg, temp_lo_reg, crc_lo_reg;
    logic        accept;
    logic [2:0]  pos;
    logic [15:0] crc_base;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;
    assign pos      = s_tuser ? POS_FIRST : pos_reg;
    assign crc_base = (pos == POS_FIRST) ? CRC_INIT : crc_reg;

    always_comb begin
        pos_next = pos_reg;
        crc_next = crc_reg;
        if (accept) begin
            if (pos < POS_CRC_LO) begin
                crc_next = crc_fold(crc_base, s_tdata);
            end else begin
                crc_next = crc_base;
            end
            pos_next = (pos == POS_CRC_HI) ? POS_FIRST : pos + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_FIRST;
            crc_reg <= CRC_INIT;
        end else begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
        end
    end

    // Capture data bytes; header bytes are not needed later
    always_ff @(posedge aclk) begin
        if (accept) begin
            case (pos)
                POS_HUM_HI:  hum_hi_reg  <= s_tdata;
                POS_HUM_LO:  hum_lo_reg  <= s_tdata;
                POS_TEMP_HI: temp_hi_reg <= s_tdata;
                POS_TEMP_LO: temp_lo_reg <= s_tdata;
                POS_CRC_LO:  crc_lo_reg  <= s_tdata;
                default:     ;
            endcase
        end
    end

    assign push                        = accept && (pos == POS_CRC_HI);
    assign push_rec.crc_ok             = (crc_reg == {s_tdata, crc_lo_reg});
    assign push_rec.humidity_tenths    = {hum_hi_reg, hum_lo_reg};
    assign push_rec.temperature_tenths = {temp_hi_reg, temp_lo_reg};

endmodule

>>> rtl/hfhi_back.sv
// ---------------------------------------------------------------------------
// hfhi_back
// Three-stage pipeline: divide by ten, table indices, lookup and risk.
// ---------------------------------------------------------------------------
module hfhi_back
    import hfhi_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_status_t q_status,
    input  frame_rec_t    pop_rec,
    output logic          pop,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [47:0]   m_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths,
                                     // [37:32] heat_index_celsius, [40:38] risk_level
    output logic          m_tuser    // [0] crc_ok
);

    localparam logic [15:0] RECIP_10 = 16'hCCCD;   // 2^19 / 10, rounded up

    // stage 1: magnitudes and reciprocal products
    logic        s1_valid_reg;
    frame_rec_t  s1_rec_reg;
    logic        s1_t_neg_reg, s1_h_neg_reg;
    logic [15:0] s1_t_mag_reg, s1_h_mag_reg;
    logic [31:0] s1_t_prod_reg, s1_h_prod_reg;

    // stage 2: table indices
    logic        s2_valid_reg;
    frame_rec_t  s2_rec_reg;
    logic [4:0]  s2_row_reg, s2_col_reg;

    // stage 3: output register
    logic        out_valid_reg;
    logic        out_crc_ok_reg;
    logic [15:0] out_hum_reg, out_temp_reg;
    logic [5:0]  out_heat_reg;
    logic [2:0]  out_risk_reg;

    logic        adv_out, adv_s2, adv_s1;
    logic [15:0] t_raw, h_raw, t_mag, h_mag;
    logic [12:0] t_q, h_q;
    logic [13:0] deg, pct;
    logic [6:0]  pct_off;
    logic [14:0] col_prod;
    logic [4:0]  row, col;
    logic [5:0]  heat;
    logic [2:0]  risk;

    assign adv_out = !out_valid_reg || m_tready;
    assign adv_s2  = !s2_valid_reg || adv_out;
    assign adv_s1  = !s1_valid_reg || adv_s2;
    assign pop     = adv_s1 && !q_status.empty;

    assign t_raw = pop_rec.temperature_tenths;
    assign h_raw = pop_rec.humidity_tenths;
    assign t_mag = t_raw[15] ? (~t_raw + 16'd1) : t_raw;
    assign h_mag = h_raw[15] ? (~h_raw + 16'd1) : h_raw;

    // Rounded-up whole units for positive values; negatives land in slot 0
    assign t_q = s1_t_prod_reg[31:19];
    assign h_q = s1_h_prod_reg[31:19];
    assign deg = {1'b0, t_q} + 14'(s1_t_mag_reg != 16'({t_q, 3'b000} + {t_q, 1'b0}));
    assign pct = {1'b0, h_q} + 14'(s1_h_mag_reg != 16'({h_q, 3'b000} + {h_q, 1'b0}));

    always_comb begin
        if (s1_t_neg_reg || deg < 14'd21) begin
            row = 5'd0;
        end else if (deg >= 14'd43) begin
            row = 5'd21;
        end else begin
            row = 5'(deg - 14'd21);
        end
    end

    // (pct - 20) / 5 by reciprocal 205 / 1024, exact below 80
    assign pct_off  = 7'(pct - 14'd20);
    assign col_prod = 15'(pct_off) * 15'd205;

    always_comb begin
        if (s1_h_neg_reg || pct < 14'd20) begin
            col = 5'd0;
        end else if (pct >= 14'd100) begin
            col = 5'd16;
        end else begin
            col = col_prod[14:10] + 5'd1;
        end
    end

    assign heat = HEAT_TABLE[s2_row_reg][s2_col_reg];

    always_comb begin
        if (heat >= 6'd31) begin
            risk = RISK_DANGER;
        end else if (heat >= 6'd28) begin
            risk = RISK_STRICT;
        end else if (heat >= 6'd25) begin
            risk = RISK_WARNING;
        end else if (heat >= 6'd21) begin
            risk = RISK_CAUTION;
        end else begin
            risk = RISK_SAFE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (adv_s1) begin
                s1_valid_reg <= pop;
            end
            if (adv_s2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv_out) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_s1) begin
            s1_rec_reg    <= pop_rec;
            s1_t_neg_reg  <= t_raw[15];
            s1_h_neg_reg  <= h_raw[15];
            s1_t_mag_reg  <= t_mag;
            s1_h_mag_reg  <= h_mag;
            s1_t_prod_reg <= t_mag * RECIP_10;
            s1_h_prod_reg <= h_mag * RECIP_10;
        end
        if (adv_s2) begin
            s2_rec_reg <= s1_rec_reg;
            s2_row_reg <= row;
            s2_col_reg <= col;
        end
        if (adv_out) begin
            out_crc_ok_reg <= s2_rec_reg.crc_ok;
            out_hum_reg    <= s2_rec_reg.humidity_tenths;
            out_temp_reg   <= s2_rec_reg.temperature_tenths;
            out_heat_reg   <= heat;
            out_risk_reg   <= risk;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_crc_ok_reg;
    assign m_tdata  = {7'd0, out_risk_reg, out_heat_reg, out_temp_reg, out_hum_reg};

endmodule

>>> rtl/humidity_frame_heat_index.sv
// ---------------------------------------------------------------------------
// humidity_frame_heat_index: sensor reply frame decoder with heat-stress index
// Throughput: one byte per cycle (CRC byte step in the front end) unless the queue is
// full, one result per frame. Each frame passes the queue and three back stages.
// Reset: synchronous active-low; clears position, CRC, queue and pipeline valids.
// ---------------------------------------------------------------------------
`include "humidity_frame_heat_index_assert.svh"

module humidity_frame_heat_index
    import hfhi_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // byte stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tuser,   // [0] frame_start
    // result stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] humidity_tenths, [31:16] temperature_tenths,
                                   // [37:32] heat_index_celsius, [40:38] risk_level
    output logic        m_tuser    // [0] crc_ok
);

    // The front end folds the CRC over bytes 0..5, holds the data bytes and,
    // on byte 7, pushes one decoded frame into a two-entry queue. The back
    // end pops frames and turns them into heat index and risk. The queue
    // lets a stalled output hold results without stopping byte intake until
    // it is full.

    queue_status_t q_status;
    frame_rec_t    push_rec, pop_rec;
    logic          push, pop;

    hfhi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_rec (push_rec)
    );

    hfhi_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .pop_rec  (pop_rec),
        .status   (q_status)
    );

    hfhi_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_status (q_status),
        .pop_rec  (pop_rec),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Never push into a full queue or pop an empty one
    `HFHI_ASSERT_IMPL(a_no_overflow, aclk, aresetn, push, !q_status.full, "queue overflow")
    `HFHI_ASSERT_IMPL(a_no_underflow, aclk, aresetn, pop, !q_status.empty, "queue underflow")
    // Risk must agree with the index it came from
    `HFHI_ASSERT_IMPL(a_risk_match, aclk, aresetn, m_tvalid,
        ((m_tdata[37:32] >= 6'd31) == (m_tdata[40:38] == RISK_DANGER)), "risk mismatch")
    // Index stays inside the table's range
    `HFHI_ASSERT_IMPL(a_heat_range, aclk, aresetn, m_tvalid,
        (m_tdata[37:32] >= 6'd15) && (m_tdata[37:32] <= 6'd46), "heat index out of range")

endmodule
